FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition a implies condition b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: implication");

// Condition a implies condition b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

FILE: rtl/ows_pkg.sv
package ows_pkg;

	localparam int unsigned ROM_BITS     = 64;
	localparam int unsigned END_POSITION = 65;
	localparam int unsigned FAMILY_LIMIT = 9;

	// Item kinds on the input channel
	typedef enum logic [2:0] {
		KIND_START_FIRST = 3'd0,
		KIND_START_NEXT  = 3'd1,
		KIND_BIT_PAIR    = 3'd2,
		KIND_TARGET      = 3'd3,
		KIND_FAMILY_SKIP = 3'd4
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_SETUP    = 3'd0,
		ST_SEND_CMD = 3'd1,
		ST_WRITE    = 3'd2,
		ST_FOUND    = 3'd3,
		ST_FAILED   = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       presence_missing;
		logic       id_bit;
		logic       complement_bit;
		logic [7:0] family_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                direction;
		logic [ROM_BITS-1:0] rom_code;
		logic                no_more_devices;
	} out_item_t;

endpackage

FILE: rtl/ows_in_if.sv
interface ows_in_if;
	import ows_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: rtl/ows_out_if.sv
interface ows_out_if;
	import ows_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: rtl/onewire_rom_search_engine_core.sv
// 1-Wire ROM search decision engine.
// in_ch takes one item per handshake: a search start (first or next, with the
// bus reset presence result), a read bit pair, a target family setup or a
// family skip. out_ch returns exactly one result per item: a status, the
// direction bit to write on the bus, the ROM register and the last-device flag.
// An accepted item is registered in the input stage; its state update and
// result are computed in one pass of logic and go to the output register.
// Throughput is one item per cycle while the receiver does not stall; the only
// loop is the search state read and written by the single stage of logic.
// Reset clears the ROM register and the search state, sets the bit position
// to one, and empties both stages.
// When the receiver stalls, the result waits in the output register and one
// more item may be held in the input stage; in_ch.ready drops only when both
// are full.
`include "assert_macros.svh"

module onewire_rom_search_engine_core (
	input logic       clk,
	input logic       arst_n,
	ows_in_if.sink    in_ch,
	ows_out_if.source out_ch
);
	import ows_pkg::*;

	// Input stage
	logic     valid_s1;
	in_item_t item_s1;

	// Output stage
	logic      out_valid_q;
	out_item_t out_item_q;

	// Search state
	logic [ROM_BITS-1:0] rom_q;
	logic [6:0]          last_disc_q;
	logic [3:0]          family_disc_q;
	logic                last_dev_q;
	logic [6:0]          bit_pos_q;
	logic [6:0]          zero_mark_q;
	logic                searching_q;

	// Next state and result
	logic [ROM_BITS-1:0] rom_d;
	logic [6:0]          last_disc_d;
	logic [3:0]          family_disc_d;
	logic                last_dev_d;
	logic [6:0]          bit_pos_d;
	logic [6:0]          zero_mark_d;
	logic                searching_d;
	status_t             res_status;
	logic                res_dir;

	logic       advance;
	logic       start_fail;
	logic [6:0] bit_pos_m1;
	logic [5:0] bit_idx;
	logic [6:0] bit_pos_p1;

	// Move the input stage forward when the output register is free
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_item_q;

	assign bit_pos_m1 = bit_pos_q - 7'd1;
	assign bit_idx    = bit_pos_m1[5:0];
	assign bit_pos_p1 = bit_pos_q + 7'd1;
	assign start_fail = item_s1.presence_missing ||
		(last_dev_q && (item_s1.kind != KIND_START_FIRST));

	// Decide the state update and the result for the item in the input stage
	always_comb begin
		rom_d         = rom_q;
		last_disc_d   = last_disc_q;
		family_disc_d = family_disc_q;
		last_dev_d    = last_dev_q;
		bit_pos_d     = bit_pos_q;
		zero_mark_d   = zero_mark_q;
		searching_d   = searching_q;
		res_status    = ST_IGNORED;
		res_dir       = 1'b0;

		unique case (item_s1.kind) inside
			KIND_START_FIRST, KIND_START_NEXT: begin
				if (item_s1.kind == KIND_START_FIRST) begin
					last_disc_d   = '0;
					family_disc_d = '0;
					last_dev_d    = 1'b0;
				end
				if (start_fail) begin
					searching_d   = 1'b0;
					last_disc_d   = '0;
					family_disc_d = '0;
					last_dev_d    = 1'b0;
					res_status    = ST_FAILED;
				end else begin
					searching_d = 1'b1;
					bit_pos_d   = 7'd1;
					zero_mark_d = '0;
					res_status  = ST_SEND_CMD;
				end
			end
			KIND_BIT_PAIR: begin
				if (!searching_q) begin
					res_status = ST_IGNORED;
				end else if (item_s1.id_bit && item_s1.complement_bit) begin
					searching_d   = 1'b0;
					last_disc_d   = '0;
					family_disc_d = '0;
					last_dev_d    = 1'b0;
					res_status    = ST_FAILED;
				end else begin
					// Pick the direction: forced bit, or discrepancy rule
					if (item_s1.id_bit != item_s1.complement_bit) begin
						res_dir = item_s1.id_bit;
					end else begin
						if (bit_pos_q < last_disc_q) begin
							res_dir = rom_q[bit_idx];
						end else begin
							res_dir = (bit_pos_q == last_disc_q);
						end
						if (!res_dir) begin
							zero_mark_d = bit_pos_q;
							if (bit_pos_q < 7'(FAMILY_LIMIT)) begin
								family_disc_d = bit_pos_q[3:0];
							end
						end
					end
					rom_d[bit_idx] = res_dir;
					bit_pos_d      = bit_pos_p1;
					if (bit_pos_p1 < 7'(END_POSITION)) begin
						res_status = ST_WRITE;
					end else begin
						// Close the pass
						searching_d = 1'b0;
						last_disc_d = zero_mark_d;
						if (zero_mark_d == 7'd0) begin
							last_dev_d = 1'b1;
						end
						if (rom_d[7:0] == 8'd0) begin
							last_disc_d   = '0;
							family_disc_d = '0;
							last_dev_d    = 1'b0;
							res_status    = ST_FAILED;
						end else begin
							res_status = ST_FOUND;
						end
					end
				end
			end
			KIND_TARGET: begin
				searching_d   = 1'b0;
				rom_d         = ROM_BITS'(item_s1.family_byte);
				last_disc_d   = 7'(ROM_BITS);
				family_disc_d = '0;
				last_dev_d    = 1'b0;
				res_status    = ST_SETUP;
			end
			KIND_FAMILY_SKIP: begin
				searching_d   = 1'b0;
				last_disc_d   = {3'd0, family_disc_q};
				family_disc_d = '0;
				if (family_disc_q == 4'd0) begin
					last_dev_d = 1'b1;
				end
				res_status = ST_SETUP;
			end
			default: begin
				res_status = ST_IGNORED;
			end
		endcase
	end

	// Hold the valid bits of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the input stage and the result register
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.payload;
		end
		if (advance) begin
			out_item_q.status          <= res_status;
			out_item_q.direction       <= res_dir;
			out_item_q.rom_code        <= rom_d;
			out_item_q.no_more_devices <= last_dev_d;
		end
	end

	// Advance the search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q         <= '0;
			last_disc_q   <= '0;
			family_disc_q <= '0;
			last_dev_q    <= 1'b0;
			bit_pos_q     <= 7'd1;
			zero_mark_q   <= '0;
			searching_q   <= 1'b0;
		end else if (advance) begin
			rom_q         <= rom_d;
			last_disc_q   <= last_disc_d;
			family_disc_q <= family_disc_d;
			last_dev_q    <= last_dev_d;
			bit_pos_q     <= bit_pos_d;
			zero_mark_q   <= zero_mark_d;
			searching_q   <= searching_d;
		end
	end

	`ASSERT_IMPLIES(a_bit_pos_range, clk, arst_n, searching_q, (bit_pos_q != 7'd0) && (bit_pos_q < 7'(END_POSITION)))
	`ASSERT_IMPLIES(a_no_pass_after_last, clk, arst_n, searching_q, !last_dev_q)
	`ASSERT_IMPLIES(a_write_in_pass, clk, arst_n, out_valid_q && (out_item_q.status == ST_WRITE), searching_q)
	`ASSERT_IMPLIES(a_found_family, clk, arst_n, out_valid_q && (out_item_q.status == ST_FOUND), out_item_q.rom_code[7:0] != 8'd0)
	`ASSERT_IMPLIES(a_stall_only_full, clk, arst_n, !in_ch.ready, valid_s1 && out_valid_q && !out_ch.ready)

endmodule
